### design/sil_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions of the scaled index load/store unit
// no dependencies

package sil_pkg;

    localparam int REG_COUNT_DEF     = 256;
    localparam int MEM_ADDR_BITS_DEF = 16;

    localparam int CMD_W     = 2;
    localparam int SIZE_W    = 3;
    localparam int REG_NUM_W = 8;
    localparam int SHIFT_W   = 6;
    localparam int DISP_W    = 32;
    localparam int ADDR_W    = 48;
    localparam int DATA_W    = 64;
    localparam int BYTES     = 8;

    typedef enum logic [CMD_W-1:0] {
        KIND_MEM_MEM = 2'd0,
        KIND_REG_MEM = 2'd1,
        KIND_MEM_REG = 2'd2,
        KIND_IMM_MEM = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        RF_DST_BASE,
        RF_DST_INDEX,
        RF_SRC_BASE,
        RF_SRC_INDEX,
        RF_DATA_REG
    } t_rf_sel;

    typedef enum logic [1:0] {
        DATA_IMM,
        DATA_REG,
        DATA_MEM
    } t_data_sel;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DB,
        S_DI,
        S_DSH,
        S_DADD,
        S_SB,
        S_SI,
        S_SSH,
        S_SADD,
        S_RR,
        S_RCAP,
        S_MRD,
        S_MCAP,
        S_MWR,
        S_RWR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic      load_item;
        logic      rf_re;
        t_rf_sel   rf_sel;
        logic      opnd_src;
        logic      acc_load;
        logic      sh_load;
        logic      ea_load;
        logic      sa_load;
        logic      regval_load;
        logic      data_load;
        t_data_sel data_sel;
        logic      mem_re;
        logic      mem_we;
        logic      mem_clear;
        logic      rf_we;
        logic      out_load;
    } t_ctrl;

    typedef struct packed {
        t_kind kind;
        logic  clear_last;
    } t_stat;

    function automatic logic [BYTES-1:0] byte_enable(input logic [SIZE_W-1:0] code);
        logic [BYTES-1:0] be;
        case (code)
            3'd0: begin
                be = 8'h01;
            end
            3'd1: begin
                be = 8'h03;
            end
            3'd2: begin
                be = 8'h0F;
            end
            3'd3: begin
                be = 8'h3F;
            end
            default: begin
                be = 8'hFF;
            end
        endcase
        return be;
    endfunction

    function automatic logic [DATA_W-1:0] expand_mask(input logic [BYTES-1:0] be);
        logic [DATA_W-1:0] m;
        for (int i = 0; i < BYTES; i++) begin
            m[8*i +: 8] = {8{be[i]}};
        end
        return m;
    endfunction

endpackage

### design/sil_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module sil_ram #(
    parameter int              WIDTH = 8,
    parameter longint unsigned DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/sil_ctrl.sv
`timescale 1ns / 1ps
// controller state machine of the scaled index load/store unit
// depends on sil_pkg

module sil_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  sil_pkg::t_stat i_stat,
    output sil_pkg::t_ctrl o_ctrl
);

    sil_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    sil_pkg::t_ctrl  ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sil_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        ctrl        = '0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            sil_pkg::S_CLEAR: begin
                ctrl.mem_clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = sil_pkg::S_IDLE;
                end
            end
            sil_pkg::S_IDLE: begin
                if (i_valid) begin
                    ctrl.load_item = 1'b1;
                    n_state        = sil_pkg::S_DB;
                end
            end
            sil_pkg::S_DB: begin
                ctrl.rf_re  = 1'b1;
                ctrl.rf_sel = sil_pkg::RF_DST_BASE;
                n_state     = sil_pkg::S_DI;
            end
            sil_pkg::S_DI: begin
                ctrl.rf_re    = 1'b1;
                ctrl.rf_sel   = sil_pkg::RF_DST_INDEX;
                ctrl.acc_load = 1'b1;
                n_state       = sil_pkg::S_DSH;
            end
            sil_pkg::S_DSH: begin
                ctrl.sh_load = 1'b1;
                n_state      = sil_pkg::S_DADD;
            end
            sil_pkg::S_DADD: begin
                ctrl.ea_load = 1'b1;
                case (i_stat.kind)
                    sil_pkg::KIND_MEM_MEM: begin
                        n_state = sil_pkg::S_SB;
                    end
                    sil_pkg::KIND_IMM_MEM: begin
                        ctrl.data_load = 1'b1;
                        ctrl.data_sel  = sil_pkg::DATA_IMM;
                        n_state        = sil_pkg::S_MWR;
                    end
                    default: begin
                        n_state = sil_pkg::S_RR;
                    end
                endcase
            end
            sil_pkg::S_SB: begin
                ctrl.rf_re    = 1'b1;
                ctrl.rf_sel   = sil_pkg::RF_SRC_BASE;
                ctrl.opnd_src = 1'b1;
                n_state       = sil_pkg::S_SI;
            end
            sil_pkg::S_SI: begin
                ctrl.rf_re    = 1'b1;
                ctrl.rf_sel   = sil_pkg::RF_SRC_INDEX;
                ctrl.opnd_src = 1'b1;
                ctrl.acc_load = 1'b1;
                n_state       = sil_pkg::S_SSH;
            end
            sil_pkg::S_SSH: begin
                ctrl.opnd_src = 1'b1;
                ctrl.sh_load  = 1'b1;
                n_state       = sil_pkg::S_SADD;
            end
            sil_pkg::S_SADD: begin
                ctrl.sa_load = 1'b1;
                n_state      = sil_pkg::S_MRD;
            end
            sil_pkg::S_RR: begin
                ctrl.rf_re  = 1'b1;
                ctrl.rf_sel = sil_pkg::RF_DATA_REG;
                n_state     = sil_pkg::S_RCAP;
            end
            sil_pkg::S_RCAP: begin
                ctrl.regval_load = 1'b1;
                if (i_stat.kind == sil_pkg::KIND_REG_MEM) begin
                    ctrl.data_load = 1'b1;
                    ctrl.data_sel  = sil_pkg::DATA_REG;
                    n_state        = sil_pkg::S_MWR;
                end else begin
                    n_state = sil_pkg::S_MRD;
                end
            end
            sil_pkg::S_MRD: begin
                ctrl.mem_re = 1'b1;
                n_state     = sil_pkg::S_MCAP;
            end
            sil_pkg::S_MCAP: begin
                ctrl.data_load = 1'b1;
                ctrl.data_sel  = sil_pkg::DATA_MEM;
                if (i_stat.kind == sil_pkg::KIND_MEM_MEM) begin
                    n_state = sil_pkg::S_MWR;
                end else begin
                    n_state = sil_pkg::S_RWR;
                end
            end
            sil_pkg::S_MWR: begin
                ctrl.mem_we = 1'b1;
                n_state     = sil_pkg::S_DONE;
            end
            sil_pkg::S_RWR: begin
                ctrl.rf_we = 1'b1;
                n_state    = sil_pkg::S_DONE;
            end
            sil_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    ctrl.out_load = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = sil_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sil_pkg::S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == sil_pkg::S_IDLE);
    assign o_valid = r_out_valid;
    assign o_ctrl  = ctrl;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == sil_pkg::S_DB))
        else $error("accepted beat did not start address generation");

    a_capture_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sil_pkg::S_MCAP) |-> ($past(r_state) == sil_pkg::S_MRD))
        else $error("memory capture without preceding read");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == sil_pkg::S_DONE))
        else $error("result raised outside done state");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sil_pkg::S_CLEAR) |=> !(ctrl.load_item && $past(ctrl.mem_clear)
            && (r_state == sil_pkg::S_CLEAR)))
        else $error("beat taken during memory clear");

endmodule

### design/sil_dp.sv
`timescale 1ns / 1ps
// datapath: register file, address generation, byte-banked data memory, result register
// depends on sil_pkg and sil_ram

module sil_dp #(
    parameter int REG_COUNT     = sil_pkg::REG_COUNT_DEF,
    parameter int MEM_ADDR_BITS = sil_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sil_pkg::t_ctrl                  i_ctrl,
    output sil_pkg::t_stat                  o_stat,
    input  logic [sil_pkg::CMD_W-1:0]       i_cmd,
    input  logic [sil_pkg::SIZE_W-1:0]      i_size_code,
    input  logic [sil_pkg::REG_NUM_W-1:0]   i_dst_base,
    input  logic [sil_pkg::REG_NUM_W-1:0]   i_dst_index,
    input  logic [sil_pkg::SHIFT_W-1:0]     i_dst_shift,
    input  logic [sil_pkg::DISP_W-1:0]      i_dst_disp,
    input  logic [sil_pkg::REG_NUM_W-1:0]   i_src_base,
    input  logic [sil_pkg::REG_NUM_W-1:0]   i_src_index,
    input  logic [sil_pkg::SHIFT_W-1:0]     i_src_shift,
    input  logic [sil_pkg::DISP_W-1:0]      i_src_disp,
    input  logic [sil_pkg::REG_NUM_W-1:0]   i_data_reg,
    input  logic [sil_pkg::DATA_W-1:0]      i_immediate,
    output logic [sil_pkg::ADDR_W-1:0]      o_effective_address,
    output logic [sil_pkg::DATA_W-1:0]      o_data_moved
);

    localparam int              RIW  = $clog2(REG_COUNT);
    localparam int              MW   = MEM_ADDR_BITS;
    localparam int              RW   = MEM_ADDR_BITS - 3;
    localparam longint unsigned ROWS = 64'(1) << RW;
    localparam int              NW   = sil_pkg::REG_NUM_W;
    localparam int              AW   = sil_pkg::ADDR_W;
    localparam int              DW   = sil_pkg::DATA_W;

    sil_pkg::t_kind               r_kind;
    logic [sil_pkg::BYTES-1:0]    r_be;
    logic [NW-1:0]                r_dst_base, r_dst_index, r_src_base, r_src_index, r_data_reg;
    logic [sil_pkg::SHIFT_W-1:0]  r_dst_shift, r_src_shift;
    logic [sil_pkg::DISP_W-1:0]   r_dst_disp, r_src_disp;
    logic [DW-1:0]                r_imm;

    logic [AW-1:0]                r_acc, r_sh, r_ea, r_sa;
    logic [DW-1:0]                r_regval, r_data;
    logic                         r_rd_zero;
    logic [REG_COUNT-1:0]         r_rf_vld;
    logic [RW-1:0]                r_clr;
    logic [AW-1:0]                r_out_ea;
    logic [DW-1:0]                r_out_data;

    logic [NW-1:0]                rd_num;
    logic                         rd_in_range, wr_in_range;
    logic [DW-1:0]                rf_rdata, rd_val, mask, rf_wdata;
    logic [sil_pkg::SHIFT_W-1:0]  sel_shift;
    logic [sil_pkg::DISP_W-1:0]   sel_disp;
    logic [MW-1:0]                rd_a, wr_a;
    logic [7:0]                   bank_rdata [sil_pkg::BYTES];
    logic [DW-1:0]                mem_word;

    // register number select
    always_comb begin
        case (i_ctrl.rf_sel)
            sil_pkg::RF_DST_BASE: begin
                rd_num = r_dst_base;
            end
            sil_pkg::RF_DST_INDEX: begin
                rd_num = r_dst_index;
            end
            sil_pkg::RF_SRC_BASE: begin
                rd_num = r_src_base;
            end
            sil_pkg::RF_SRC_INDEX: begin
                rd_num = r_src_index;
            end
            default: begin
                rd_num = r_data_reg;
            end
        endcase
    end

    assign rd_in_range = ({1'b0, rd_num} < (NW+1)'(REG_COUNT));
    assign wr_in_range = ({1'b0, r_data_reg} < (NW+1)'(REG_COUNT));
    assign rd_val      = r_rd_zero ? '0 : rf_rdata;
    assign mask        = sil_pkg::expand_mask(r_be);
    assign rf_wdata    = (r_regval & ~mask) | r_data;
    assign sel_shift   = i_ctrl.opnd_src ? r_src_shift : r_dst_shift;
    assign sel_disp    = i_ctrl.opnd_src ? r_src_disp : r_dst_disp;

    sil_ram #(
        .WIDTH (DW),
        .DEPTH (REG_COUNT)
    ) u_rf (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.rf_we && wr_in_range),
        .i_waddr (r_data_reg[RIW-1:0]),
        .i_wdata (rf_wdata),
        .i_re    (i_ctrl.rf_re),
        .i_raddr (rd_num[RIW-1:0]),
        .o_rdata (rf_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_item) begin
            r_kind      <= sil_pkg::t_kind'(i_cmd);
            r_be        <= sil_pkg::byte_enable(i_size_code);
            r_dst_base  <= i_dst_base;
            r_dst_index <= i_dst_index;
            r_dst_shift <= i_dst_shift;
            r_dst_disp  <= i_dst_disp;
            r_src_base  <= i_src_base;
            r_src_index <= i_src_index;
            r_src_shift <= i_src_shift;
            r_src_disp  <= i_src_disp;
            r_data_reg  <= i_data_reg;
            r_imm       <= i_immediate;
        end
        if (i_ctrl.rf_re) begin
            r_rd_zero <= !rd_in_range || !r_rf_vld[rd_num[RIW-1:0]];
        end
        if (i_ctrl.acc_load) begin
            r_acc <= rd_val[AW-1:0] + AW'(sel_disp);
        end
        if (i_ctrl.sh_load) begin
            r_sh <= rd_val[AW-1:0] << sel_shift;
        end
        if (i_ctrl.ea_load) begin
            r_ea <= r_acc + r_sh;
        end
        if (i_ctrl.sa_load) begin
            r_sa <= r_acc + r_sh;
        end
        if (i_ctrl.regval_load) begin
            r_regval <= rd_val;
        end
        if (i_ctrl.data_load) begin
            case (i_ctrl.data_sel)
                sil_pkg::DATA_IMM: begin
                    r_data <= r_imm & mask;
                end
                sil_pkg::DATA_REG: begin
                    r_data <= rd_val & mask;
                end
                default: begin
                    r_data <= mem_word & mask;
                end
            endcase
        end
        if (i_ctrl.out_load) begin
            r_out_ea   <= r_ea;
            r_out_data <= r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_rf_vld <= '0;
        end else begin
            if (i_ctrl.mem_clear) begin
                r_clr <= r_clr + RW'(1);
            end
            if (i_ctrl.rf_we && wr_in_range) begin
                r_rf_vld[r_data_reg[RIW-1:0]] <= 1'b1;
            end
        end
    end

    // byte lanes: byte at address a lives in bank a[2:0], row a[MW-1:3]
    assign rd_a = (r_kind == sil_pkg::KIND_MEM_MEM) ? r_sa[MW-1:0] : r_ea[MW-1:0];
    assign wr_a = r_ea[MW-1:0];

    for (genvar b = 0; b < sil_pkg::BYTES; b++) begin : g_bank
        logic [2:0]    wr_off;
        logic [RW-1:0] wr_row, rd_row;
        logic          we;
        logic [7:0]    wdata;

        assign wr_off = 3'(b) - wr_a[2:0];
        assign wr_row = i_ctrl.mem_clear ? r_clr
                                         : wr_a[MW-1:3] + RW'(3'(b) < wr_a[2:0]);
        assign rd_row = rd_a[MW-1:3] + RW'(3'(b) < rd_a[2:0]);
        assign we     = i_ctrl.mem_clear || (i_ctrl.mem_we && r_be[wr_off]);
        assign wdata  = i_ctrl.mem_clear ? 8'h00 : r_data[{wr_off, 3'b000} +: 8];

        sil_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (wr_row),
            .i_wdata (wdata),
            .i_re    (i_ctrl.mem_re),
            .i_raddr (rd_row),
            .o_rdata (bank_rdata[b])
        );
    end

    always_comb begin
        for (int i = 0; i < sil_pkg::BYTES; i++) begin
            mem_word[8*i +: 8] = bank_rdata[3'(rd_a[2:0] + 3'(i))];
        end
    end

    assign o_stat.kind       = r_kind;
    assign o_stat.clear_last = &r_clr;

    assign o_effective_address = r_out_ea;
    assign o_data_moved        = r_out_data;

endmodule

### design/scaled_index_load_store_unit_top.sv
`timescale 1ns / 1ps
// top level of the scaled index load/store unit: controller plus datapath
// depends on sil_pkg, sil_ctrl, sil_dp
//
// usage:
// - input channel i_valid/o_ready carries one move instruction per beat
//   (kind, size, destination and source operand fields, data register, immediate)
// - output channel o_valid/i_ready returns one beat per instruction: the
//   48-bit address of the first memory operand and the moved value
// - each instruction runs through a sequencer that reads the register file one
//   operand per cycle and the byte-banked data memory through one read port;
//   memory to memory runs the most steps and immediate to memory the fewest;
//   the next beat is taken only once the sequencer is back in its idle state
// - after reset the data memory is cleared, one row of eight bytes a cycle,
//   2^(MEM_ADDR_BITS-3) rows (8192 at the default); no beat is taken then;
//   the register file reads as zero until written
// - the result sits in an output register; the next instruction is taken
//   and executed while it waits, and only its own result waits for i_ready

module scaled_index_load_store_unit_top #(
    parameter int REG_COUNT     = sil_pkg::REG_COUNT_DEF,
    parameter int MEM_ADDR_BITS = sil_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [sil_pkg::CMD_W-1:0]       i_cmd,
    input  logic [sil_pkg::SIZE_W-1:0]      i_size_code,
    input  logic [sil_pkg::REG_NUM_W-1:0]   i_dst_base,
    input  logic [sil_pkg::REG_NUM_W-1:0]   i_dst_index,
    input  logic [sil_pkg::SHIFT_W-1:0]     i_dst_shift,
    input  logic [sil_pkg::DISP_W-1:0]      i_dst_disp,
    input  logic [sil_pkg::REG_NUM_W-1:0]   i_src_base,
    input  logic [sil_pkg::REG_NUM_W-1:0]   i_src_index,
    input  logic [sil_pkg::SHIFT_W-1:0]     i_src_shift,
    input  logic [sil_pkg::DISP_W-1:0]      i_src_disp,
    input  logic [sil_pkg::REG_NUM_W-1:0]   i_data_reg,
    input  logic [sil_pkg::DATA_W-1:0]      i_immediate,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [sil_pkg::ADDR_W-1:0]      o_effective_address,
    output logic [sil_pkg::DATA_W-1:0]      o_data_moved
);

    sil_pkg::t_ctrl ctrl;
    sil_pkg::t_stat stat;

    sil_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    sil_dp #(
        .REG_COUNT     (REG_COUNT),
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctrl              (ctrl),
        .o_stat              (stat),
        .i_cmd               (i_cmd),
        .i_size_code         (i_size_code),
        .i_dst_base          (i_dst_base),
        .i_dst_index         (i_dst_index),
        .i_dst_shift         (i_dst_shift),
        .i_dst_disp          (i_dst_disp),
        .i_src_base          (i_src_base),
        .i_src_index         (i_src_index),
        .i_src_shift         (i_src_shift),
        .i_src_disp          (i_src_disp),
        .i_data_reg          (i_data_reg),
        .i_immediate         (i_immediate),
        .o_effective_address (o_effective_address),
        .o_data_moved        (o_data_moved)
    );

endmodule
